### rtl/world_to_screen_projection_defines.svh
// ----------------------------------------------------------------------------
// World-to-screen projection assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// The property must hold at every clock edge out of reset.
`define WSP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true out of reset.
`define WSP_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Widths, constants and payload types shared by the projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

	localparam int FRAC     = 16;
	localparam int DATA_W   = 32;
	// Sum of three full products, with headroom.
	localparam int SUM_W    = 66;
	// Dot product after flooring and adding the offset.
	localparam int D_W      = SUM_W - FRAC + 1;
	localparam int SIZE_W   = 14;
	// Numerator c * size + d of the pixel offset division.
	localparam int N_W      = D_W + SIZE_W + 2;
	// Pixel offsets are clamped to +-2^PIX_LOG.
	localparam int PIX_LOG  = 40;
	localparam int PM_W     = PIX_LOG + 1;
	localparam int NU_W     = PIX_LOG + 3;
	localparam int SQ_W     = 32;
	localparam int DEN_W    = SIZE_W + 1;
	localparam int SH       = SQ_W - FRAC;
	localparam int TOP_W    = NU_W - SH;
	// Remainder width of the pixel offset division.
	localparam int PR_W     = D_W;
	// Smallest visible depth: 1000 * d >= 2^FRAC.
	localparam int VIS_MIN  = ((1 << FRAC) + 999) / 1000;
	localparam int CH_LAT   = PIX_LOG + SQ_W + 6;

	localparam logic [SQ_W-1:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [SQ_W-1:0] SAT_MIN = 32'h8000_0000;
	localparam logic [PM_W-1:0] PIX_MAX = PM_W'(1) << PIX_LOG;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
	} point_t;

	typedef struct packed {
		logic                     visible;
		logic signed [DATA_W-1:0] screen_u;
		logic signed [DATA_W-1:0] screen_v;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] coef_x;
		logic signed [DATA_W-1:0] coef_y;
		logic signed [DATA_W-1:0] coef_z;
		logic signed [DATA_W-1:0] offset;
	} row_t;

	typedef struct packed {
		logic                  visible;
		logic signed [D_W-1:0] depth;
		logic signed [D_W-1:0] clip_x;
		logic signed [D_W-1:0] clip_y;
	} mid_t;

endpackage

`default_nettype wire

### rtl/wsp_front.sv
// ----------------------------------------------------------------------------
// Projection front end
// Forms depth, clip x and clip y of each point and classifies visibility.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_front (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                wsp_pkg::row_t row_d,
	input  wire                wsp_pkg::row_t row_x,
	input  wire                wsp_pkg::row_t row_y,
	input  wire                logic push,
	output logic               full,
	input  wire                wsp_pkg::point_t point,
	output logic               mid_push,
	input  wire                logic mid_full,
	output wsp_pkg::mid_t      mid_item
);
	import wsp_pkg::*;

	row_t                    rows [3];
	logic                    en;
	logic                    v_s1, v_s2, v_s3;
	logic signed [63:0]      prod_s1 [3][3];
	logic signed [SUM_W-1:0] sum_s2 [3];
	logic signed [D_W-1:0]   dot_s3 [3];

	assign rows[0] = row_d;
	assign rows[1] = row_x;
	assign rows[2] = row_y;

	// The whole front stalls only when its last stage cannot hand over.
	assign en   = !v_s3 || !mid_full;
	assign full = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= rows[r].coef_x * point.pos_x;
				prod_s1[r][1] <= rows[r].coef_y * point.pos_y;
				prod_s1[r][2] <= rows[r].coef_z * point.pos_z;
				sum_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
					+ SUM_W'(prod_s1[r][2]);
				// Flooring the exact sum equals the per-term split with carry.
				dot_s3[r] <= D_W'(sum_s2[r] >>> FRAC) + D_W'(rows[r].offset);
			end
		end
	end

	assign mid_push         = v_s3;
	assign mid_item.visible = dot_s3[0] >= $signed(D_W'(VIS_MIN));
	assign mid_item.depth   = dot_s3[0];
	assign mid_item.clip_x  = dot_s3[1];
	assign mid_item.clip_y  = dot_s3[2];

endmodule

`default_nettype wire

### rtl/wsp_queue.sv
// ----------------------------------------------------------------------------
// Projection decoupling queue
// Two-entry show-ahead queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "world_to_screen_projection_defines.svh"

module wsp_queue (
	input  wire           logic clk,
	input  wire           logic arst_n,
	input  wire           logic push,
	output logic          full,
	input  wire           wsp_pkg::mid_t wr_item,
	input  wire           logic pop,
	output logic          empty,
	output wsp_pkg::mid_t rd_item
);
	import wsp_pkg::*;

	mid_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wr_item;
	end

	`WSP_NEVER(a_no_overflow, count_q == 2'd3, "queue count exceeded its depth")
	`WSP_NEVER(a_no_underflow, pop && empty, "back end read from an empty queue")
	`WSP_ASSERT(a_count_up, (do_push && !do_pop) |=> count_q == $past(count_q) + 2'd1, "count stuck")

endmodule

`default_nettype wire

### rtl/wsp_chan.sv
// ----------------------------------------------------------------------------
// Projection screen channel
// Pixel offset division, viewport mapping and normalizing division for one
// screen axis, as a pipeline of restoring division steps.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_chan (
	input  wire  logic clk,
	input  wire  logic en,
	input  wire  logic signed [wsp_pkg::N_W-1:0] num,
	input  wire  logic [wsp_pkg::D_W-1:0] den,
	input  wire  logic [wsp_pkg::SIZE_W-1:0] size,
	input  wire  logic flip,
	output logic [wsp_pkg::SQ_W-1:0] res
);
	import wsp_pkg::*;

	logic [DEN_W-1:0] den2;

	// Stage A and B: magnitude and range check of the pixel division.
	logic [N_W-1:0]  mag_a_q;
	logic            neg_a_q;
	logic [PR_W-1:0] den_a_q;
	logic [PR_W-1:0] top_b;

	logic [PR_W-1:0]    prem_q   [PIX_LOG];
	logic [PIX_LOG-1:0] plow_q   [PIX_LOG];
	logic [PR_W-1:0]    pden_q   [PIX_LOG];
	logic [PIX_LOG-1:0] pq_q     [PIX_LOG+1];
	logic               pneg_q   [PIX_LOG+1];
	logic               pclamp_q [PIX_LOG+1];

	logic [PM_W-1:0]        mclamp;
	logic [PM_W:0]          mtwice;
	logic signed [NU_W-1:0] nu_c_q;
	logic [NU_W-1:0]        mag2_d_q;
	logic                   sgn_d_q;
	logic [TOP_W-1:0]       top_e;

	logic [DEN_W-1:0] srem_q [SQ_W];
	logic [SQ_W-1:0]  slow_q [SQ_W];
	logic [SQ_W-1:0]  sq_q   [SQ_W+1];
	logic             ssgn_q [SQ_W+1];
	logic             ssat_q [SQ_W+1];

	logic [SQ_W-1:0] qfin;
	logic [SQ_W-1:0] res_q;

	assign den2  = {size, 1'b0};
	assign top_b = PR_W'(mag_a_q >> PIX_LOG);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_q <= num[N_W-1] ? N_W'(-num) : N_W'(num);
			neg_a_q <= num[N_W-1] ^ flip;
			den_a_q <= den;

			// A quotient of 2^PIX_LOG or more clamps, so only the low bits are formed.
			pclamp_q[0] <= top_b >= den_a_q;
			prem_q[0]   <= top_b;
			plow_q[0]   <= mag_a_q[PIX_LOG-1:0];
			pden_q[0]   <= den_a_q;
			pq_q[0]     <= '0;
			pneg_q[0]   <= neg_a_q;
		end
	end

	for (genvar k = 0; k < PIX_LOG; k++) begin : g_pix
		logic [PR_W:0] trial;
		logic          ge;

		assign trial = {prem_q[k], plow_q[k][PIX_LOG-1]};
		assign ge    = trial >= {1'b0, pden_q[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				pq_q[k+1]     <= {pq_q[k][PIX_LOG-2:0], ge};
				pneg_q[k+1]   <= pneg_q[k];
				pclamp_q[k+1] <= pclamp_q[k];
			end
		end

		if (k < PIX_LOG - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					prem_q[k+1] <= ge ? PR_W'(trial - {1'b0, pden_q[k]}) : trial[PR_W-1:0];
					plow_q[k+1] <= {plow_q[k][PIX_LOG-2:0], 1'b0};
					pden_q[k+1] <= pden_q[k];
				end
			end
		end
	end

	// The viewport mapping adds or subtracts twice the offset magnitude.
	assign mclamp = pclamp_q[PIX_LOG] ? PIX_MAX : {1'b0, pq_q[PIX_LOG]};
	assign mtwice = {mclamp, 1'b0};
	assign top_e  = TOP_W'(mag2_d_q >> SH);

	always_ff @(posedge clk) begin
		if (en) begin
			nu_c_q <= pneg_q[PIX_LOG]
				? $signed(NU_W'(size)) - $signed(NU_W'(mtwice))
				: $signed(NU_W'(size)) + $signed(NU_W'(mtwice));

			mag2_d_q <= nu_c_q[NU_W-1] ? NU_W'(-nu_c_q) : NU_W'(nu_c_q);
			sgn_d_q  <= nu_c_q[NU_W-1];

			ssat_q[0] <= top_e >= TOP_W'(den2);
			srem_q[0] <= top_e[DEN_W-1:0];
			slow_q[0] <= {mag2_d_q[SH-1:0], {FRAC{1'b0}}};
			sq_q[0]   <= '0;
			ssgn_q[0] <= sgn_d_q;
		end
	end

	for (genvar k = 0; k < SQ_W; k++) begin : g_scale
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {srem_q[k], slow_q[k][SQ_W-1]};
		assign ge    = trial >= {1'b0, den2};

		always_ff @(posedge clk) begin
			if (en) begin
				sq_q[k+1]   <= {sq_q[k][SQ_W-2:0], ge};
				ssgn_q[k+1] <= ssgn_q[k];
				ssat_q[k+1] <= ssat_q[k];
			end
		end

		if (k < SQ_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					srem_q[k+1] <= ge ? DEN_W'(trial - {1'b0, den2}) : trial[DEN_W-1:0];
					slow_q[k+1] <= {slow_q[k][SQ_W-2:0], 1'b0};
				end
			end
		end
	end

	assign qfin = sq_q[SQ_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ssgn_q[SQ_W]) begin
				res_q <= (ssat_q[SQ_W] || qfin[SQ_W-1]) ? SAT_MAX : qfin;
			end else begin
				res_q <= (ssat_q[SQ_W] || qfin > SAT_MIN) ? SAT_MIN : SQ_W'(-qfin);
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

### rtl/wsp_back.sv
// ----------------------------------------------------------------------------
// Projection back end
// Scales clip values by the viewport size, runs both screen channels and
// holds finished results in a two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_back (
	input  wire              logic clk,
	input  wire              logic arst_n,
	input  wire              logic [wsp_pkg::SIZE_W-1:0] size_w,
	input  wire              logic [wsp_pkg::SIZE_W-1:0] size_h,
	input  wire              logic mid_empty,
	output logic             mid_pop,
	input  wire              wsp_pkg::mid_t mid_item,
	input  wire              logic pop,
	output logic             empty,
	output wsp_pkg::result_t result
);
	import wsp_pkg::*;

	logic                  en;
	logic                  v_s1, vis_s1;
	logic signed [N_W-1:0] num_x_s1, num_y_s1;
	logic [D_W-1:0]        den_s1;
	logic [CH_LAT-1:0]     v_pipe_q, vis_pipe_q;
	logic                  v_last, vis_last;
	logic [SQ_W-1:0]       res_u, res_v;

	result_t    oq_q [2];
	logic       oq_wp_q, oq_rp_q;
	logic [1:0] oq_count_q;
	logic       oq_full, oq_push, oq_pop;
	result_t    oq_item;

	assign v_last   = v_pipe_q[CH_LAT-1];
	assign vis_last = vis_pipe_q[CH_LAT-1];
	assign oq_full  = oq_count_q == 2'd2;
	assign en       = !v_last || !oq_full;
	assign mid_pop  = en && !mid_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_pipe_q <= '0;
		end else if (en) begin
			v_s1     <= mid_pop;
			v_pipe_q <= {v_pipe_q[CH_LAT-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s1     <= mid_item.visible;
			num_x_s1   <= mid_item.clip_x * $signed({1'b0, size_w}) + mid_item.depth;
			num_y_s1   <= mid_item.clip_y * $signed({1'b0, size_h}) + mid_item.depth;
			den_s1     <= {mid_item.depth[D_W-2:0], 1'b0};
			vis_pipe_q <= {vis_pipe_q[CH_LAT-2:0], vis_s1};
		end
	end

	wsp_chan u_chan_u (
		.clk  (clk),
		.en   (en),
		.num  (num_x_s1),
		.den  (den_s1),
		.size (size_w),
		.flip (1'b0),
		.res  (res_u)
	);

	// The screen y axis runs downward, so its pixel offset is subtracted.
	wsp_chan u_chan_v (
		.clk  (clk),
		.en   (en),
		.num  (num_y_s1),
		.den  (den_s1),
		.size (size_h),
		.flip (1'b1),
		.res  (res_v)
	);

	assign oq_item.visible  = vis_last;
	assign oq_item.screen_u = vis_last ? $signed(res_u) : '0;
	assign oq_item.screen_v = vis_last ? $signed(res_v) : '0;

	assign oq_push = v_last && en;
	assign oq_pop  = pop && !empty;
	assign empty   = oq_count_q == 2'd0;
	assign result  = oq_q[oq_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q    <= 1'b0;
			oq_rp_q    <= 1'b0;
			oq_count_q <= 2'd0;
		end else begin
			if (oq_push) oq_wp_q <= ~oq_wp_q;
			if (oq_pop) oq_rp_q <= ~oq_rp_q;
			oq_count_q <= oq_count_q + {1'b0, oq_push} - {1'b0, oq_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) oq_q[oq_wp_q] <= oq_item;
	end

endmodule

`default_nettype wire

### rtl/world_to_screen_projection.sv
// Pipeline: a point passes 3 front stages, the queue write, 1 scaling stage,
// 78 channel stages and the output queue write before it reaches the result port.
// Throughput: one point per cycle unless a full queue stalls the pipeline, set by
// the fully pipelined division steps.
// Reset: arst_n clears both queues and all valid bits at once and restores the
// registers to zero coefficients and a 1280 by 720 viewport; no clearing pass.
// ----------------------------------------------------------------------------
// World-to-screen projection
// Projects world points with three configured rows onto normalized screen
// coordinates, decoupling the dot product front end from the division back end.
// ----------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection (
	input  wire              logic clk,
	input  wire              logic arst_n,
	input  wire              logic push,
	output logic             full,
	input  wire              wsp_pkg::point_t point,
	input  wire              logic pop,
	output logic             empty,
	output wsp_pkg::result_t result,
	input  wire              logic cfg_we,
	input  wire              logic [2:0] cfg_index,
	input  wire              logic [63:0] cfg_data
);
	import wsp_pkg::*;

	typedef enum logic [2:0] {
		REG_COL2_XY,
		REG_COL2_ZW,
		REG_COL3_XY,
		REG_COL3_ZW,
		REG_COL4_XY,
		REG_COL4_ZW,
		REG_VIEW_W,
		REG_VIEW_H
	} reg_idx_t;

	logic [63:0]       col_q [6];
	logic [SIZE_W-1:0] width_q, height_q;
	logic [SIZE_W-1:0] size_w, size_h;
	row_t              row_x, row_y, row_d;

	logic mid_push, mid_full, mid_pop, mid_empty;
	mid_t mid_wr, mid_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) col_q[i] <= '0;
			width_q  <= SIZE_W'(1280);
			height_q <= SIZE_W'(720);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COL2_XY: col_q[0] <= cfg_data;
				REG_COL2_ZW: col_q[1] <= cfg_data;
				REG_COL3_XY: col_q[2] <= cfg_data;
				REG_COL3_ZW: col_q[3] <= cfg_data;
				REG_COL4_XY: col_q[4] <= cfg_data;
				REG_COL4_ZW: col_q[5] <= cfg_data;
				REG_VIEW_W:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_VIEW_H:  height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero viewport size behaves as one pixel.
	assign size_w = (width_q == '0) ? SIZE_W'(1) : width_q;
	assign size_h = (height_q == '0) ? SIZE_W'(1) : height_q;

	assign row_x = '{coef_x: col_q[0][63:32], coef_y: col_q[0][31:0],
		coef_z: col_q[1][63:32], offset: col_q[1][31:0]};
	assign row_y = '{coef_x: col_q[2][63:32], coef_y: col_q[2][31:0],
		coef_z: col_q[3][63:32], offset: col_q[3][31:0]};
	assign row_d = '{coef_x: col_q[4][63:32], coef_y: col_q[4][31:0],
		coef_z: col_q[5][63:32], offset: col_q[5][31:0]};

	wsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.row_d    (row_d),
		.row_x    (row_x),
		.row_y    (row_y),
		.push     (push),
		.full     (full),
		.point    (point),
		.mid_push (mid_push),
		.mid_full (mid_full),
		.mid_item (mid_wr)
	);

	wsp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.full    (mid_full),
		.wr_item (mid_wr),
		.pop     (mid_pop),
		.empty   (mid_empty),
		.rd_item (mid_rd)
	);

	wsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.size_w    (size_w),
		.size_h    (size_h),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_item  (mid_rd),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire
